[src/rmte_pkg.sv]
// Shared types and constants of the register map translation engine.
`default_nettype none
package rmte_pkg;

   typedef enum logic [2:0] {
      MODE_LOAD       = 3'd0,
      MODE_INGEST     = 3'd1,
      MODE_DEV_READ   = 3'd2,
      MODE_DEV_WRITE  = 3'd3,
      MODE_POOL_READ  = 3'd4,
      MODE_POOL_WRITE = 3'd5,
      MODE_RANGE      = 3'd6,
      MODE_ILLEGAL    = 3'd7
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK               = 2'd0,
      STATUS_ILLEGAL_FUNCTION = 2'd1,
      STATUS_ILLEGAL_ADDRESS  = 2'd2,
      STATUS_POOL_RANGE       = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SRC_ZERO   = 2'd0,
      SRC_POOL   = 2'd1,
      SRC_MASKED = 2'd2
   } src_type;

   localparam logic [1:0] ACC_READ_ONLY  = 2'd0;
   localparam logic [1:0] ACC_WRITE_ONLY = 2'd1;
   localparam logic [1:0] ACC_READ_WRITE = 2'd2;
   localparam logic [1:0] ACC_RESERVED   = 2'd3;

   typedef struct packed {
      logic       latch;
      logic       clr_step;
      logic       tbl_write;
      logic       tbl_read_mid;
      logic       tbl_read_scan;
      logic       go_lower;
      logic       go_upper;
      logic       pool_read_direct;
      logic       pool_read_entry;
      logic       pool_write_direct;
      logic       pool_write_entry;
      logic       scan_next;
      logic       addr_next;
      logic       result_load;
      status_type result_status;
      src_type    result_src;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     clear_done;
      logic     slot_ok;
      logic     outside_block;
      logic     direct_oob;
      logic     range_bad;
      logic     lo_lt_hi;
      logic     entry_hit;
      logic     entry_less;
      logic     entry_oob;
      logic     scan_more;
      logic     pool_match;
      logic     access_denied;
      logic     last_addr;
   } sts_type;

endpackage
`default_nettype wire

[src/rmte_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rmte_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic                                  rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                      rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

[src/rmte_ctrl.sv]
// Controller state machine of the register map translation engine.
`default_nettype none
module rmte_ctrl
   import rmte_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output cmd_type      cmd,
   input  wire sts_type sts
);
   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_DECODE, ST_SEARCH, ST_SEARCH_WAIT,
      ST_SCAN, ST_SCAN_WAIT, ST_FINISH
   } state_type;

   state_type  state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   status_type res_status_ff, res_status_in;
   src_type    res_src_ff, res_src_in;

   always_comb begin
      cmd           = '0;
      state_in      = state_ff;
      res_status_in = res_status_ff;
      res_src_in    = res_src_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_DECODE;
            end
         end
         ST_DECODE: begin
            res_status_in = STATUS_OK;
            res_src_in    = SRC_ZERO;
            state_in      = ST_FINISH;
            case (sts.mode)
               MODE_LOAD: begin
                  if (sts.slot_ok) cmd.tbl_write = 1'b1;
                  else res_status_in = STATUS_ILLEGAL_ADDRESS;
               end
               MODE_INGEST: begin
                  if (sts.outside_block) res_status_in = STATUS_ILLEGAL_ADDRESS;
                  else state_in = ST_SEARCH;
               end
               MODE_DEV_READ, MODE_DEV_WRITE: begin
                  state_in = ST_SEARCH;
               end
               MODE_POOL_READ: begin
                  if (sts.direct_oob) begin
                     res_status_in = STATUS_POOL_RANGE;
                  end else begin
                     cmd.pool_read_direct = 1'b1;
                     res_src_in           = SRC_POOL;
                  end
               end
               MODE_POOL_WRITE: begin
                  if (sts.direct_oob) res_status_in = STATUS_POOL_RANGE;
                  else cmd.pool_write_direct = 1'b1;
               end
               MODE_RANGE: begin
                  if (sts.range_bad) res_status_in = STATUS_ILLEGAL_ADDRESS;
                  else state_in = ST_SCAN;
               end
               default: begin
                  res_status_in = STATUS_ILLEGAL_FUNCTION;
               end
            endcase
         end
         ST_SEARCH: begin
            if (sts.lo_lt_hi) begin
               cmd.tbl_read_mid = 1'b1;
               state_in         = ST_SEARCH_WAIT;
            end else begin
               res_status_in = STATUS_ILLEGAL_ADDRESS;
               state_in      = ST_FINISH;
            end
         end
         ST_SEARCH_WAIT: begin
            if (sts.entry_hit) begin
               state_in = ST_FINISH;
               if (sts.entry_oob) begin
                  res_status_in = STATUS_POOL_RANGE;
               end else if (sts.mode == MODE_DEV_READ) begin
                  cmd.pool_read_entry = 1'b1;
                  res_src_in          = SRC_MASKED;
               end else begin
                  cmd.pool_write_entry = 1'b1;
               end
            end else begin
               cmd.go_lower = sts.entry_less;
               cmd.go_upper = !sts.entry_less;
               state_in     = ST_SEARCH;
            end
         end
         ST_SCAN: begin
            if (sts.scan_more) begin
               cmd.tbl_read_scan = 1'b1;
               state_in          = ST_SCAN_WAIT;
            end else begin
               res_status_in = STATUS_ILLEGAL_ADDRESS;
               state_in      = ST_FINISH;
            end
         end
         ST_SCAN_WAIT: begin
            if (sts.pool_match) begin
               if (sts.access_denied) begin
                  res_status_in = STATUS_ILLEGAL_FUNCTION;
                  state_in      = ST_FINISH;
               end else if (sts.last_addr) begin
                  state_in = ST_FINISH;
               end else begin
                  cmd.addr_next = 1'b1;
                  state_in      = ST_SCAN;
               end
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.result_load = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      cmd.result_status = res_status_ff;
      cmd.result_src    = res_src_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         rsp_valid_ff  <= 1'b0;
         res_status_ff <= STATUS_OK;
         res_src_ff    <= SRC_ZERO;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         res_status_ff <= res_status_in;
         res_src_ff    <= res_src_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
endmodule
`default_nettype wire

[src/rmte_dp.sv]
// Datapath of the register map translation engine: request registers, table and pool.
`default_nettype none
module rmte_dp
   import rmte_pkg::*;
#(
   parameter int TABLE_DEPTH = 64,
   parameter int POOL_SIZE   = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output sts_type          sts,
   input  wire logic [2:0]  req_mode,
   input  wire logic [5:0]  req_entry_index,
   input  wire logic [15:0] req_device_address,
   input  wire logic [15:0] req_pool_address,
   input  wire logic [1:0]  req_access_kind,
   input  wire logic [15:0] req_data_value,
   input  wire logic [15:0] req_read_mask,
   input  wire logic [15:0] req_item_offset,
   input  wire logic [15:0] req_range_count,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [6:0]  csr_data,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_read_value
);
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int PW = $clog2(POOL_SIZE);
   localparam int EW = 34;

   mode_type         mode_ff;
   logic [5:0]       idx_ff;
   logic [15:0]      dev_ff, pa_ff, val_ff, mask_ff, off_ff, cnt_ff, addr_ff;
   logic [1:0]       acc_ff;
   logic [6:0]       count_ff;
   logic [CW-1:0]    lo_ff, hi_ff, scan_ff, active, mid;
   logic [PW-1:0]    clr_ff;
   logic [1:0]       rsp_status_ff;
   logic [15:0]      rsp_value_ff;

   logic [EW-1:0]    tbl_rd_data;
   logic [15:0]      ent_dev, ent_pool, cur_addr, pool_rd_data;
   logic [1:0]       ent_acc;
   logic             tbl_rd_en, pool_wr_en, pool_rd_en;
   logic [AW-1:0]    tbl_wr_addr, tbl_rd_addr;
   logic [PW-1:0]    pool_wr_addr, pool_rd_addr;
   logic [15:0]      pool_wr_data;
   logic [16:0]      range_end;

   assign active = ({25'd0, count_ff} > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(count_ff);
   assign mid    = lo_ff + ((hi_ff - lo_ff) >> 1);

   assign ent_dev  = tbl_rd_data[33:18];
   assign ent_pool = tbl_rd_data[17:2];
   assign ent_acc  = tbl_rd_data[1:0];
   assign cur_addr = pa_ff + addr_ff;
   assign range_end = {1'b0, pa_ff} + {1'b0, cnt_ff};

   always_comb begin
      sts               = '0;
      sts.mode          = mode_ff;
      sts.clear_done    = (clr_ff == PW'(POOL_SIZE - 1));
      sts.slot_ok       = ({26'd0, idx_ff} < 32'(TABLE_DEPTH));
      sts.outside_block = (off_ff >= cnt_ff);
      sts.direct_oob    = ({16'd0, pa_ff} >= 32'(POOL_SIZE));
      sts.range_bad     = (cnt_ff == 16'd0) || (range_end > 17'h10000);
      sts.lo_lt_hi      = (lo_ff < hi_ff);
      sts.entry_hit     = (ent_dev == dev_ff);
      sts.entry_less    = (ent_dev < dev_ff);
      sts.entry_oob     = ({16'd0, ent_pool} >= 32'(POOL_SIZE));
      sts.scan_more     = (scan_ff < active);
      sts.pool_match    = (ent_pool == cur_addr);
      sts.access_denied = (acc_ff == ACC_READ_ONLY && ent_acc == ACC_WRITE_ONLY) ||
                          (acc_ff == ACC_WRITE_ONLY && ent_acc == ACC_READ_ONLY);
      sts.last_addr     = (addr_ff == cnt_ff - 16'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 7'd0;
         clr_ff   <= '0;
      end else begin
         if (csr_valid && csr_ready) count_ff <= csr_data;
         if (cmd.clr_step) clr_ff <= clr_ff + PW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         mode_ff <= mode_type'(req_mode);
         idx_ff  <= req_entry_index;
         dev_ff  <= (mode_type'(req_mode) == MODE_INGEST) ?
                    req_device_address + req_item_offset : req_device_address;
         pa_ff   <= req_pool_address;
         acc_ff  <= req_access_kind;
         val_ff  <= req_data_value;
         mask_ff <= req_read_mask;
         off_ff  <= req_item_offset;
         cnt_ff  <= req_range_count;
         lo_ff   <= '0;
         hi_ff   <= active;
         scan_ff <= '0;
         addr_ff <= 16'd0;
      end
      if (cmd.go_lower) lo_ff <= mid + CW'(1);
      if (cmd.go_upper) hi_ff <= mid;
      if (cmd.scan_next) scan_ff <= scan_ff + CW'(1);
      if (cmd.addr_next) begin
         scan_ff <= '0;
         addr_ff <= addr_ff + 16'd1;
      end
      if (cmd.result_load) begin
         rsp_status_ff <= cmd.result_status;
         case (cmd.result_src)
            SRC_POOL:   rsp_value_ff <= pool_rd_data;
            SRC_MASKED: rsp_value_ff <= pool_rd_data & mask_ff;
            default:    rsp_value_ff <= 16'd0;
         endcase
      end
   end

   assign tbl_wr_addr = AW'(idx_ff);
   assign tbl_rd_en   = cmd.tbl_read_mid || cmd.tbl_read_scan;
   assign tbl_rd_addr = cmd.tbl_read_mid ? mid[AW-1:0] : scan_ff[AW-1:0];

   rmte_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (cmd.tbl_write),
      .wr_addr (tbl_wr_addr),
      .wr_data ({dev_ff, pa_ff, acc_ff}),
      .rd_en   (tbl_rd_en),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   assign pool_wr_en   = cmd.clr_step || cmd.pool_write_direct || cmd.pool_write_entry;
   assign pool_wr_addr = cmd.clr_step ? clr_ff :
                         cmd.pool_write_direct ? PW'(pa_ff) : PW'(ent_pool);
   assign pool_wr_data = cmd.clr_step ? 16'd0 : val_ff;
   assign pool_rd_en   = cmd.pool_read_direct || cmd.pool_read_entry;
   assign pool_rd_addr = cmd.pool_read_direct ? PW'(pa_ff) : PW'(ent_pool);

   rmte_ram #(.WIDTH(16), .DEPTH(POOL_SIZE)) u_pool (
      .clock   (clock),
      .wr_en   (pool_wr_en),
      .wr_addr (pool_wr_addr),
      .wr_data (pool_wr_data),
      .rd_en   (pool_rd_en),
      .rd_addr (pool_rd_addr),
      .rd_data (pool_rd_data)
   );

   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_value_ff;
endmodule
`default_nettype wire

[src/register_map_translation_engine.sv]
// Top level of the register map translation engine.
// Requests arrive on the req_ channel, one beat per operation, and each gives
// exactly one rsp_ beat carrying a status code and a read value.
// The csr_ channel writes the number of table entries in use; write it only
// while no request is in flight.
// Load entry and direct pool access end right after decode. Device-address
// operations run a binary search of the table RAM (up to log2(TABLE_DEPTH)+1
// probes) and give an illegal-address status when the address is not found.
// A range check runs a linear scan of the table entries, restarting it for
// each pool address, so its work grows with range_count times entry_count.
// One request is in work at a time; the next beat is taken once the result is
// in the output register, even if the receiver has not yet taken it.
// After reset the pool RAM is zeroed, one word per cycle, through all POOL_SIZE
// words; req_ready stays low meanwhile while csr_ writes are still taken.
// A stalled receiver holds the result in the output register and the next
// request waits in its final step until the register frees.
`default_nettype none
module register_map_translation_engine
   import rmte_pkg::*;
#(
   parameter int TABLE_DEPTH = 64,
   parameter int POOL_SIZE   = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_mode,
   input  wire logic [5:0]  req_entry_index,
   input  wire logic [15:0] req_device_address,
   input  wire logic [15:0] req_pool_address,
   input  wire logic [1:0]  req_access_kind,
   input  wire logic [15:0] req_data_value,
   input  wire logic [15:0] req_read_mask,
   input  wire logic [15:0] req_item_offset,
   input  wire logic [15:0] req_range_count,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_read_value,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [6:0]  csr_data
);
   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   rmte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   rmte_dp #(.TABLE_DEPTH(TABLE_DEPTH), .POOL_SIZE(POOL_SIZE)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_mode           (req_mode),
      .req_entry_index    (req_entry_index),
      .req_device_address (req_device_address),
      .req_pool_address   (req_pool_address),
      .req_access_kind    (req_access_kind),
      .req_data_value     (req_data_value),
      .req_read_mask      (req_read_mask),
      .req_item_offset    (req_item_offset),
      .req_range_count    (req_range_count),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_data           (csr_data),
      .rsp_status         (rsp_status),
      .rsp_read_value     (rsp_read_value)
   );
endmodule
`default_nettype wire
